// ===== rtl/core/lps_pkg.sv =====
// Shared definitions for the line pixel stepper: default sizes, command kinds
// and the stream byte-padding helper. No dependencies.
`default_nettype none

package lps_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 32;

    // Kind of an input beat, carried on s_tuser.
    typedef enum logic
    {
        OP_BEGIN   = 1'b0,
        OP_ADVANCE = 1'b1
    } lps_op_t;

    // Round a field width up to whole bytes for tdata.
    function automatic int byte_pad(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lps_front.sv =====
// Front end of the line pixel stepper: accepts input beats, classifies them
// and orders the endpoints. Depends on lps_pkg.
`default_nettype none

module lps_front #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // start_x, start_y, end_x, end_y, color (lowest bit up)
    input  wire logic [lps_pkg::byte_pad(4 * COORD_BITS
                       + lps_pkg::COLOR_BITS)-1:0]       s_tdata,
    // op
    input  wire logic                                    s_tuser,
    output logic                                         cmd_valid,
    input  wire logic                                    cmd_ready,
    output logic                                         cmd_adv,
    output logic [COORD_BITS-1:0]                        cmd_x0,
    output logic [COORD_BITS-1:0]                        cmd_y0,
    output logic [COORD_BITS-1:0]                        cmd_dx,
    output logic [COORD_BITS:0]                          cmd_dy,
    output logic [lps_pkg::COLOR_BITS-1:0]               cmd_color
);

    localparam int CW = COORD_BITS;

    logic [CW-1:0] start_x;
    logic [CW-1:0] start_y;
    logic [CW-1:0] end_x;
    logic [CW-1:0] end_y;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
    logic          swap;

    assign start_x   = s_tdata[CW-1:0];
    assign start_y   = s_tdata[2*CW-1:CW];
    assign end_x     = s_tdata[3*CW-1:2*CW];
    assign end_y     = s_tdata[4*CW-1:3*CW];
    assign cmd_color = s_tdata[4*CW+lps_pkg::COLOR_BITS-1:4*CW];

    assign cmd_valid = s_tvalid;
    assign s_tready  = cmd_ready;
    assign cmd_adv   = (lps_pkg::lps_op_t'(s_tuser) == lps_pkg::OP_ADVANCE);

    // order endpoints so x never decreases along the line
    assign swap   = (start_x > end_x);
    assign cmd_x0 = swap ? end_x : start_x;
    assign cmd_y0 = swap ? end_y : start_y;
    assign x1     = swap ? start_x : end_x;
    assign y1     = swap ? start_y : end_y;

    assign cmd_dx = x1 - cmd_x0;
    assign cmd_dy = {1'b0, y1} - {1'b0, cmd_y0};

endmodule

`default_nettype wire

// ===== rtl/core/lps_queue.sv =====
// Two-entry command queue between the front and back ends of the line
// pixel stepper. No package dependencies.
`default_nettype none

module lps_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNTW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNTW'(1);
            2'b01:   count_next = count_reg - CNTW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lps_back.sv =====
// Back end of the line pixel stepper: octant setup, decision stepping and
// the output register. Depends on lps_pkg.
`default_nettype none

module lps_back #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire logic                              cmd_adv,
    input  wire logic [COORD_BITS-1:0]             cmd_x0,
    input  wire logic [COORD_BITS-1:0]             cmd_y0,
    input  wire logic [COORD_BITS-1:0]             cmd_dx,
    input  wire logic [COORD_BITS:0]               cmd_dy,
    input  wire logic [lps_pkg::COLOR_BITS-1:0]    cmd_color,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [COORD_BITS-1:0]                  pixel_x,
    output logic [COORD_BITS-1:0]                  pixel_y,
    output logic [lps_pkg::COLOR_BITS-1:0]         pixel_color,
    output logic                                   pixel_last,
    output logic [COORD_BITS-1:0]                  pixels_left
);

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 4;
    localparam int IW = COORD_BITS + 3;
    localparam int KW = lps_pkg::COLOR_BITS;

    // line state
    logic [CW-1:0]        cur_x_reg,  cur_x_next;
    logic [CW-1:0]        cur_y_reg,  cur_y_next;
    logic signed [DW-1:0] dec_reg,    dec_next;
    logic [CW-1:0]        left_reg,   left_next;
    logic                 major_y_reg,   major_y_next;
    logic                 major_neg_reg, major_neg_next;
    logic                 minor_neg_reg, minor_neg_next;
    logic signed [IW-1:0] inc_major_reg, inc_major_next;
    logic signed [IW-1:0] inc_both_reg,  inc_both_next;
    logic                 test_nn_reg,   test_nn_next;
    logic [KW-1:0]        color_reg,     color_next;

    // output stage
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        out_x_reg,     out_x_next;
    logic [CW-1:0]        out_y_reg,     out_y_next;
    logic [KW-1:0]        out_color_reg, out_color_next;
    logic                 out_last_reg,  out_last_next;

    // setup terms
    logic                 fire;
    logic                 dx_pos;
    logic                 dy_pos;
    logic                 dy_neg;
    logic [CW:0]          ady;
    logic                 y_major;
    logic signed [DW-1:0] dxs;
    logic signed [DW-1:0] dys;
    logic signed [DW-1:0] tdx;
    logic signed [DW-1:0] tdy;
    logic signed [DW-1:0] tdx2;
    logic signed [DW-1:0] tdy2;

    // step terms
    logic                 take;
    logic signed [IW-1:0] inc_sel;
    logic                 move_x;
    logic                 move_y;
    logic                 neg_x;
    logic                 neg_y;
    logic [CW-1:0]        step_x;
    logic [CW-1:0]        step_y;

    assign cmd_ready   = !out_valid_reg || out_ready;
    assign fire        = cmd_valid && cmd_ready;
    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign pixel_last  = out_last_reg;
    assign pixels_left = left_reg;

    // octant classification; sx = dx>0 ? 1 : -1, sy = dy>0 ? 1 : -1
    assign dx_pos  = |cmd_dx;
    assign dy_neg  = cmd_dy[CW];
    assign dy_pos  = !dy_neg && (|cmd_dy);
    assign ady     = dy_neg ? -cmd_dy : cmd_dy;
    assign y_major = (ady[CW-1:0] > cmd_dx);
    assign dxs     = $signed({{(DW-CW){1'b0}}, cmd_dx});
    assign dys     = $signed({{(DW-CW-1){cmd_dy[CW]}}, cmd_dy});
    assign tdy     = dx_pos ? dys : -dys;   // dy * sx
    assign tdx     = dy_pos ? dxs : -dxs;   // dx * sy
    assign tdy2    = tdy <<< 1;
    assign tdx2    = tdx <<< 1;

    // minor step folds into one add: both = major + minor increment
    assign take    = test_nn_reg ? !dec_reg[DW-1] : (dec_reg[DW-1] || (dec_reg == '0));
    assign inc_sel = take ? inc_both_reg : inc_major_reg;
    assign move_x  = !major_y_reg || take;
    assign move_y  = major_y_reg || take;
    assign neg_x   = major_y_reg ? minor_neg_reg : major_neg_reg;
    assign neg_y   = major_y_reg ? major_neg_reg : minor_neg_reg;
    assign step_x  = cur_x_reg + (neg_x ? {CW{1'b1}} : CW'(1));
    assign step_y  = cur_y_reg + (neg_y ? {CW{1'b1}} : CW'(1));

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        dec_next       = dec_reg;
        left_next      = left_reg;
        major_y_next   = major_y_reg;
        major_neg_next = major_neg_reg;
        minor_neg_next = minor_neg_reg;
        inc_major_next = inc_major_reg;
        inc_both_next  = inc_both_reg;
        test_nn_next   = test_nn_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        if (fire && !cmd_adv)
        begin
            cur_x_next    = cmd_x0;
            cur_y_next    = cmd_y0;
            color_next    = cmd_color;
            major_y_next  = y_major;
            inc_both_next = IW'(tdy2 - tdx2);
            if (y_major)
            begin
                dec_next       = tdy - tdx2;
                inc_major_next = IW'(-tdx2);
                major_neg_next = !dy_pos;
                minor_neg_next = !dx_pos;
                test_nn_next   = dx_pos ^ dy_pos;
                left_next      = ady[CW-1:0];
            end
            else
            begin
                dec_next       = tdy2 - tdx;
                inc_major_next = IW'(tdy2);
                major_neg_next = !dx_pos;
                minor_neg_next = !dy_pos;
                test_nn_next   = !(dx_pos ^ dy_pos);
                left_next      = cmd_dx;
            end
            out_valid_next = 1'b1;
            out_x_next     = cmd_x0;
            out_y_next     = cmd_y0;
            out_color_next = cmd_color;
            out_last_next  = (left_next == '0);
        end
        else if (fire && (left_reg != '0))
        begin
            dec_next       = dec_reg + {{(DW-IW){inc_sel[IW-1]}}, inc_sel};
            cur_x_next     = move_x ? step_x : cur_x_reg;
            cur_y_next     = move_y ? step_y : cur_y_reg;
            left_next      = left_reg - CW'(1);
            out_valid_next = 1'b1;
            out_x_next     = cur_x_next;
            out_y_next     = cur_y_next;
            out_color_next = color_reg;
            out_last_next  = (left_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            dec_reg       <= '0;
            left_reg      <= '0;
            major_y_reg   <= 1'b0;
            major_neg_reg <= 1'b0;
            minor_neg_reg <= 1'b0;
            inc_major_reg <= '0;
            inc_both_reg  <= '0;
            test_nn_reg   <= 1'b1;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            dec_reg       <= dec_next;
            left_reg      <= left_next;
            major_y_reg   <= major_y_next;
            major_neg_reg <= major_neg_next;
            minor_neg_reg <= minor_neg_next;
            inc_major_reg <= inc_major_next;
            inc_both_reg  <= inc_both_next;
            test_nn_reg   <= test_nn_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/line_pixel_stepper_top.sv =====
// Line pixel stepper: Bresenham line rasterizer in all eight octants.
// Input beats on s_*: tuser = 0 begins a line from start/end points and a
// color and yields its first pixel; tuser = 1 asks for the next pixel. An
// advance beat after the final pixel, or before any line, yields no beat.
// Output beats on m_*: one pixel each, tlast set on the line's final pixel.
// A begin beat during a line drops the old line at once.
// An accepted beat passes through the command queue and then the back end's
// output register before its pixel appears on m_tvalid.
// Throughput: one input beat and one pixel per cycle while m_tready is
// high; the back end's decision update is one add and sign test per step.
// A two-entry command queue decouples s_tready from m_tready: while m_tready
// is low the queue fills and s_tready drops only when both entries are held.
// Reset clears the line state (no line active) and empties the queue and
// the output register.
// Depends on lps_pkg, lps_front, lps_queue, lps_back.
`default_nettype none

module line_pixel_stepper_top #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // start_x, start_y, end_x, end_y, color (lowest bit up), zero pad
    input  wire logic [lps_pkg::byte_pad(4 * COORD_BITS
                       + lps_pkg::COLOR_BITS)-1:0]       s_tdata,
    // op
    input  wire logic                                    s_tuser,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // pixel_x, pixel_y, pixel_color (lowest bit up), zero pad
    output logic [lps_pkg::byte_pad(2 * COORD_BITS
                       + lps_pkg::COLOR_BITS)-1:0]       m_tdata,
    // last
    output logic                                         m_tlast
);

    localparam int CW  = COORD_BITS;
    localparam int KW  = lps_pkg::COLOR_BITS;
    localparam int QW  = 4 * CW + 2 + KW;
    localparam int MDW = lps_pkg::byte_pad(2 * CW + KW);

    logic          f_valid;
    logic          f_ready;
    logic          f_adv;
    logic [CW-1:0] f_x0;
    logic [CW-1:0] f_y0;
    logic [CW-1:0] f_dx;
    logic [CW:0]   f_dy;
    logic [KW-1:0] f_color;

    logic          q_valid;
    logic          q_ready;
    logic [QW-1:0] q_word;

    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [KW-1:0] pcolor;
    logic [CW-1:0] pixels_left;

    lps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_adv   (f_adv),
        .cmd_x0    (f_x0),
        .cmd_y0    (f_y0),
        .cmd_dx    (f_dx),
        .cmd_dy    (f_dy),
        .cmd_color (f_color)
    );

    lps_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_adv, f_color, f_dy, f_dx, f_y0, f_x0}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_word)
    );

    lps_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd_adv     (q_word[QW-1]),
        .cmd_x0      (q_word[CW-1:0]),
        .cmd_y0      (q_word[2*CW-1:CW]),
        .cmd_dx      (q_word[3*CW-1:2*CW]),
        .cmd_dy      (q_word[4*CW:3*CW]),
        .cmd_color   (q_word[4*CW+KW:4*CW+1]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pixel_x     (px),
        .pixel_y     (py),
        .pixel_color (pcolor),
        .pixel_last  (m_tlast),
        .pixels_left (pixels_left)
    );

    assign m_tdata = MDW'({pcolor, py, px});

`ifndef SYNTHESIS
    // a held pixel's last flag must agree with the remaining count
    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (pixels_left == '0)))
        else $error("tlast disagrees with remaining pixel count");

    // a begin command always yields a pixel beat next cycle
    a_begin_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && !q_word[QW-1]) |=> m_tvalid)
        else $error("begin command produced no pixel");

    // an advance with no line active yields nothing
    a_idle_advance_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && q_word[QW-1] && (pixels_left == '0)) |=> !m_tvalid)
        else $error("advance past line end produced a pixel");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for line_pixel_stepper_top: directed table plus random lines,
// every pixel beat checked against an in-bench Bresenham stepper or a typed pixel.
// Depends on lps_pkg and the line_pixel_stepper_top RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 12;
    localparam int S_BITS     = lps_pkg::byte_pad(4 * COORD_BITS + lps_pkg::COLOR_BITS);
    localparam int M_BITS     = lps_pkg::byte_pad(2 * COORD_BITS + lps_pkg::COLOR_BITS);
    localparam int WATCHDOG   = 1000;
    localparam int DRAIN      = 12;
    localparam int ITEM_GOAL  = 750;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed
    {
        coord_t      x;
        coord_t      y;
        logic [31:0] color;
        logic        last;
    } pixel_t;

    typedef enum int
    {
        ROW_PREDICT,
        ROW_NO_PIXEL,
        ROW_PIXEL
    } row_kind_t;

    typedef struct
    {
        lps_pkg::lps_op_t op;
        coord_t           ax, ay, bx, by;
        logic [31:0]      color;
        row_kind_t        kind;
        pixel_t           px;
    } stim_row_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;
    logic              m_tlast;

    line_pixel_stepper_top #(.COORD_BITS(COORD_BITS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // Stepper state, mirrors the block's line registers
    coord_t             pos_x, pos_y;
    logic signed [15:0] err_acc;
    logic [12:0]        steps_left;
    logic               y_major, major_neg, minor_neg, step_on_nonneg;
    logic signed [14:0] major_inc, minor_inc;
    logic [31:0]        line_rgb;

    pixel_t    pending_pixels[$];
    stim_row_t directed_rows[$];

    int error_count    = 0;
    int pixels_checked = 0;
    int pixel_beats    = 0;
    int beats_sent     = 0;
    int lines_begun    = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int rx_count       = 0;
    int rx_mode        = 0;

    function automatic coord_t step_coord(input coord_t v, input logic negative);
        return negative ? v - coord_t'(1) : v + coord_t'(1);
    endfunction

    // Advance the line state by one beat; returns 1 when a pixel comes out.
    function automatic bit rasterize(input lps_pkg::lps_op_t op, input coord_t ax,
                                     input coord_t ay, input coord_t bx, input coord_t by,
                                     input logic [31:0] col, output pixel_t px);
        int  x0, y0, x1, y1, dx, dy, sx, sy, ady;
        bit  take;
        px = '0;
        if (op == lps_pkg::OP_BEGIN)
        begin
            if (ax > bx)
            begin
                x0 = bx; y0 = by; x1 = ax; y1 = ay;
            end
            else
            begin
                x0 = ax; y0 = ay; x1 = bx; y1 = by;
            end
            dx  = x1 - x0;
            dy  = y1 - y0;
            sx  = (dx > 0) ? 1 : -1;
            sy  = (dy > 0) ? 1 : -1;
            ady = (dy < 0) ? -dy : dy;
            pos_x    = coord_t'(x0);
            pos_y    = coord_t'(y0);
            line_rgb = col;
            if (ady > dx)
            begin
                y_major        = 1'b1;
                major_inc      = 15'(-2 * dx * sy);
                minor_inc      = 15'(2 * dy * sx);
                err_acc        = 16'(dy * sx - 2 * dx * sy);
                major_neg      = sy < 0;
                minor_neg      = sx < 0;
                step_on_nonneg = (dx > 0) ? !(dy > 0) : (dy > 0);
                steps_left     = 13'(ady);
            end
            else
            begin
                y_major        = 1'b0;
                major_inc      = 15'(2 * dy * sx);
                minor_inc      = 15'(-2 * dx * sy);
                err_acc        = 16'(2 * dy * sx - dx * sy);
                major_neg      = sx < 0;
                minor_neg      = sy < 0;
                step_on_nonneg = (dx > 0) ? (dy > 0) : !(dy > 0);
                steps_left     = 13'(dx);
            end
        end
        else
        begin
            if (steps_left == 0)
                return 1'b0;
            take = step_on_nonneg ? (err_acc >= 0) : (err_acc <= 0);
            if (take)
            begin
                err_acc = err_acc + minor_inc;
                if (y_major)
                    pos_x = step_coord(pos_x, minor_neg);
                else
                    pos_y = step_coord(pos_y, minor_neg);
            end
            err_acc = err_acc + major_inc;
            if (y_major)
                pos_y = step_coord(pos_y, major_neg);
            else
                pos_x = step_coord(pos_x, major_neg);
            steps_left = steps_left - 13'd1;
        end
        px = '{x: pos_x, y: pos_y, color: line_rgb, last: (steps_left == 0)};
        return 1'b1;
    endfunction

    function automatic void add_row(input lps_pkg::lps_op_t op, input int ax, input int ay,
                                    input int bx, input int by,
                                    input logic [31:0] col, input row_kind_t kind,
                                    input pixel_t px);
        stim_row_t r;
        r = '{op, coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by), col, kind, px};
        directed_rows.push_back(r);
    endfunction

    // One input beat: burst/gap pacing, handshake, then prediction on acceptance.
    task automatic drive_beat(input lps_pkg::lps_op_t op, input coord_t ax, input coord_t ay,
                              input coord_t bx, input coord_t by, input logic [31:0] col,
                              input row_kind_t kind, input pixel_t typed_px);
        pixel_t px;
        bit     has_px;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {col, by, bx, ay, ax};
        do
            @(posedge clk);
        while (!s_tready);
        has_px = rasterize(op, ax, ay, bx, by, col, px);
        beats_sent++;
        if (op == lps_pkg::OP_BEGIN)
            lines_begun++;
        if (has_px)
            pixel_beats++;
        case (kind)
            ROW_PREDICT:
                if (has_px)
                    pending_pixels.push_back(px);
            ROW_PIXEL:
                pending_pixels.push_back(typed_px);
            default:
                ;
        endcase
        burst_left--;
        @(negedge clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
        $display("%0d ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
        error_count++;
    endtask

    // Output beat checker
    always @(posedge clk)
    begin
        pixel_t exp_px;
        pixel_t got_px;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_px = '{x: m_tdata[11:0], y: m_tdata[23:12], color: m_tdata[55:24],
                       last: m_tlast};
            if (pending_pixels.size() == 0)
            begin
                $display("%0d ns: unexpected pixel beat, expected none, got x=%0d y=%0d",
                         $time, got_px.x, got_px.y);
                error_count++;
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                pixels_checked++;
                if (got_px.x !== exp_px.x)
                    report_field("pixel_x", exp_px.x, got_px.x);
                if (got_px.y !== exp_px.y)
                    report_field("pixel_y", exp_px.y, got_px.y);
                if (got_px.color !== exp_px.color)
                    report_field("pixel_color", exp_px.color, got_px.color);
                if (got_px.last !== exp_px.last)
                    report_field("last", exp_px.last, got_px.last);
            end
        end
    end

    // Receiver backpressure: random modes, redrawn when the hold counter runs out
    always @(negedge clk)
    begin
        if (rx_count == 0)
        begin
            rx_mode  <= $urandom_range(0, 3);
            rx_count <= $urandom_range(20, 80);
        end
        else
        begin
            rx_count <= rx_count - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_count % 4 == 0);
            default: m_tready <= (rx_count < 8);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG)
        begin
            $display("%0d ns: no beat moved for %0d cycles", $time, WATCHDOG);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        coord_t      ax, ay, bx, by;
        int          kind, dxl, dyl, n_adv;
        logic [31:0] col;

        add_row(lps_pkg::OP_ADVANCE, 4095, 4095, 4095, 4095, '1, ROW_NO_PIXEL, '0);
        add_row(lps_pkg::OP_BEGIN, 0, 0, 0, 0, 32'h0, ROW_PIXEL,
                '{12'd0, 12'd0, 32'h0, 1'b1});
        add_row(lps_pkg::OP_ADVANCE, 0, 0, 0, 0, 32'h0, ROW_NO_PIXEL, '0);
        add_row(lps_pkg::OP_BEGIN, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF, ROW_PIXEL,
                '{12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1});
        add_row(lps_pkg::OP_BEGIN, 0, 7, 3, 7, 32'hA5A5_A5A5, ROW_PIXEL,
                '{12'd0, 12'd7, 32'hA5A5_A5A5, 1'b0});
        repeat (3) add_row(lps_pkg::OP_ADVANCE, 12'hABC, 12'h543, 12'hFFF, 12'h000,
                           32'h5A5A_5A5A, ROW_PREDICT, '0);
        add_row(lps_pkg::OP_ADVANCE, 0, 0, 0, 0, 32'h0, ROW_NO_PIXEL, '0);
        // reversed endpoints, steep with y falling
        add_row(lps_pkg::OP_BEGIN, 9, 2, 6, 8, 32'h1234_5678, ROW_PREDICT, '0);
        repeat (2) add_row(lps_pkg::OP_ADVANCE, 0, 0, 0, 0, 32'h0, ROW_PREDICT, '0);
        // vertical line cuts the previous one short
        add_row(lps_pkg::OP_BEGIN, 100, 50, 100, 45, 32'h0F0F_0F0F, ROW_PIXEL,
                '{12'd100, 12'd50, 32'h0F0F_0F0F, 1'b0});
        repeat (5) add_row(lps_pkg::OP_ADVANCE, 0, 0, 0, 0, 32'h0, ROW_PREDICT, '0);
        add_row(lps_pkg::OP_BEGIN, 0, 0, 4095, 4095, 32'h8000_0001, ROW_PIXEL,
                '{12'd0, 12'd0, 32'h8000_0001, 1'b0});
        repeat (2) add_row(lps_pkg::OP_ADVANCE, 0, 0, 0, 0, 32'h0, ROW_PREDICT, '0);
        add_row(lps_pkg::OP_BEGIN, 0, 4095, 4095, 0, 32'h7FFF_FFFE, ROW_PIXEL,
                '{12'd0, 12'd4095, 32'h7FFF_FFFE, 1'b0});
        add_row(lps_pkg::OP_ADVANCE, 0, 0, 0, 0, 32'h0, ROW_PREDICT, '0);
        add_row(lps_pkg::OP_BEGIN, 4095, 0, 0, 4095, 32'hC3C3_3C3C, ROW_PREDICT, '0);
        add_row(lps_pkg::OP_ADVANCE, 0, 0, 0, 0, 32'h0, ROW_PREDICT, '0);

        pos_x = '0; pos_y = '0; err_acc = '0; steps_left = '0;
        y_major = 1'b0; major_neg = 1'b0; minor_neg = 1'b0;
        major_inc = '0; minor_inc = '0; step_on_nonneg = 1'b1; line_rgb = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            drive_beat(directed_rows[i].op, directed_rows[i].ax, directed_rows[i].ay,
                       directed_rows[i].bx, directed_rows[i].by, directed_rows[i].color,
                       directed_rows[i].kind, directed_rows[i].px);

        while (beats_sent < ITEM_GOAL)
        begin
            kind = $urandom_range(0, 9);
            ax = coord_t'(($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4095 : 0)
                                                      : $urandom_range(0, 4095));
            ay = coord_t'(($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4095 : 0)
                                                      : $urandom_range(0, 4095));
            dxl = $urandom_range(0, 24);
            dyl = $urandom_range(0, 24);
            if (kind == 1)
            begin
                // axis-aligned, diagonal or single-point lines
                case ($urandom_range(0, 3))
                    0:       dxl = 0;
                    1:       dyl = 0;
                    2:       dyl = dxl;
                    default:
                    begin
                        dxl = 0;
                        dyl = 0;
                    end
                endcase
            end
            if (($urandom_range(0, 1) && ax >= dxl) || ax + dxl > 4095)
                bx = coord_t'(ax - dxl);
            else
                bx = coord_t'(ax + dxl);
            if (($urandom_range(0, 1) && ay >= dyl) || ay + dyl > 4095)
                by = coord_t'(ay - dyl);
            else
                by = coord_t'(ay + dyl);
            if (kind == 0)
            begin
                bx = coord_t'($urandom_range(0, 4095));
                by = coord_t'($urandom_range(0, 4095));
            end
            col = $urandom;
            drive_beat(lps_pkg::OP_BEGIN, ax, ay, bx, by, col, ROW_PREDICT, '0);

            n_adv = steps_left;
            if (kind == 0 && n_adv > 30)
                n_adv = $urandom_range(0, 30);
            else if ($urandom_range(0, 7) == 0)
                n_adv = $urandom_range(0, n_adv);      // abandon mid-line
            else
                n_adv = n_adv + $urandom_range(0, 2);  // advances past the end
            repeat (n_adv)
                drive_beat(lps_pkg::OP_ADVANCE, coord_t'($urandom_range(0, 4095)),
                           coord_t'($urandom_range(0, 4095)),
                           coord_t'($urandom_range(0, 4095)),
                           coord_t'($urandom_range(0, 4095)), $urandom,
                           ROW_PREDICT, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d beats over %0d lines; checked %0d pixel beats, %0d mismatches.",
                 beats_sent, lines_begun, pixels_checked, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
